[hw/rtl/vns_pkg.sv]
// ----------------------------------------------------------------------------
// vns_pkg
// Shared types, widths and constants for the Voronoi nearest-site shader.
// ----------------------------------------------------------------------------
package vns_pkg;

    // Port field widths
    localparam int SITE_IDX_W     = 9;
    localparam int COORD_W        = 15;
    localparam int PAL_W          = 6;
    localparam int SHADE_W        = 8;
    localparam int SITE_COUNT_W   = 10;
    localparam int COLOUR_COUNT_W = 7;

    localparam int S_TDATA_W  = 48;   // 45 bits of fields, zero filled
    localparam int M_TDATA_W  = 24;   // 17 bits of fields, zero filled
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 10;

    // Parameter defaults
    localparam int MAX_SITES_DEF  = 512;
    localparam int COORD_BITS_DEF = 15;

    // Shade arithmetic: 50 + floor(pal * 175 / cc), capped at 225
    localparam int DIVIDEND_W = 14;   // 63 * 175 = 11025
    localparam int DIVISOR_W  = COLOUR_COUNT_W;
    localparam logic [DIVIDEND_W-1:0] SHADE_BASE = DIVIDEND_W'(50);
    localparam logic [DIVIDEND_W-1:0] SHADE_SPAN = DIVIDEND_W'(175);
    localparam logic [SHADE_W-1:0]    SHADE_MAX  = SHADE_W'(225);

    // Item kind carried on s_tuser
    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SITE_COUNT   = 1'b0,
        CFG_COLOUR_COUNT = 1'b1
    } cfg_idx_t;

    // Top level sequencer
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DIV,
        ST_EMIT
    } state_t;

    // Scanner status
    typedef struct packed {
        logic busy;
        logic done;
    } scan_stat_t;

    // Divider request
    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } div_req_t;

endpackage

[hw/rtl/vns_ram.sv]
// ----------------------------------------------------------------------------
// vns_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module vns_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 512
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/vns_div.sv]
// ----------------------------------------------------------------------------
// vns_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module vns_div (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  vns_pkg::div_req_t              req,
    output logic                           done,
    output logic [vns_pkg::DIVIDEND_W-1:0] quotient
);

    localparam int QW = vns_pkg::DIVIDEND_W;
    localparam int DW = vns_pkg::DIVISOR_W;
    localparam int CNT_W = $clog2(QW + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DW-1:0]    rem_reg, rem_next;
    logic [QW-1:0]    quo_reg, quo_next;
    logic [DW-1:0]    dsr_reg, dsr_next;
    logic [DW:0]      trial;
    logic             fits;

    always_comb begin
        trial     = {rem_reg, quo_reg[QW-1]};
        fits      = (trial >= {1'b0, dsr_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(QW);
            rem_next  = '0;
            quo_next  = req.dividend;
            dsr_next  = req.divisor;
        end else if (busy_reg) begin
            rem_next = fits ? DW'(trial - {1'b0, dsr_reg}) : trial[DW-1:0];
            quo_next = {quo_reg[QW-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[hw/rtl/vns_scan.sv]
// ----------------------------------------------------------------------------
// vns_scan
// Site scanner: reads one site per cycle, pipelines the squared distance
// and keeps the running minimum (lower index wins on ties).
// ----------------------------------------------------------------------------
module vns_scan #(
    parameter int MAX_SITES  = vns_pkg::MAX_SITES_DEF,
    parameter int COORD_BITS = vns_pkg::COORD_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic [COORD_BITS-1:0]            qx,
    input  logic [COORD_BITS-1:0]            qy,
    input  logic [$clog2(MAX_SITES+1)-1:0]   count,
    output logic                             ram_re,
    output logic [$clog2(MAX_SITES)-1:0]     ram_raddr,
    input  logic [2*COORD_BITS+vns_pkg::PAL_W-1:0] ram_rdata,
    output vns_pkg::scan_stat_t              stat,
    output logic [$clog2(MAX_SITES)-1:0]     best_site,
    output logic [vns_pkg::PAL_W-1:0]        best_pal
);

    localparam int AW = $clog2(MAX_SITES);
    localparam int CW = $clog2(MAX_SITES + 1);
    localparam int SW = 2 * COORD_BITS;     // one square
    localparam int DW = 2 * COORD_BITS + 1; // sum of squares
    localparam int PW = vns_pkg::PAL_W;

    // Issue
    logic                  iss_reg, iss_next;
    logic [CW-1:0]         addr_reg, addr_next;
    logic [CW-1:0]         n_reg;
    logic [COORD_BITS-1:0] qx_reg, qy_reg;
    logic                  iss_last;

    // Read data stage
    logic          p0_valid_reg, p0_last_reg;
    logic [AW-1:0] p0_idx_reg;

    // Abs diff stage
    logic                  s1_valid_reg, s1_last_reg;
    logic [AW-1:0]         s1_idx_reg;
    logic [COORD_BITS-1:0] s1_dx_reg, s1_dy_reg;
    logic [PW-1:0]         s1_pal_reg;

    // Square stage
    logic          s2_valid_reg, s2_last_reg;
    logic [AW-1:0] s2_idx_reg;
    logic [SW-1:0] s2_sqx_reg, s2_sqy_reg;
    logic [PW-1:0] s2_pal_reg;

    // Sum stage
    logic          s3_valid_reg, s3_last_reg;
    logic [AW-1:0] s3_idx_reg;
    logic [DW-1:0] s3_dist_reg;
    logic [PW-1:0] s3_pal_reg;

    // Running best
    logic [DW-1:0] best_dist_reg;
    logic [AW-1:0] best_idx_reg;
    logic [PW-1:0] best_pal_reg;
    logic          done_reg;
    logic          take;

    logic [COORD_BITS-1:0] rd_x, rd_y;
    logic [PW-1:0]         rd_pal;

    assign rd_x   = ram_rdata[COORD_BITS-1:0];
    assign rd_y   = ram_rdata[2*COORD_BITS-1:COORD_BITS];
    assign rd_pal = ram_rdata[2*COORD_BITS+PW-1:2*COORD_BITS];

    assign iss_last = ((addr_reg + CW'(1)) == n_reg);

    always_comb begin
        iss_next  = iss_reg;
        addr_next = addr_reg;
        if (start) begin
            iss_next  = 1'b1;
            addr_next = '0;
        end else if (iss_reg) begin
            addr_next = addr_reg + CW'(1);
            if (iss_last) begin
                iss_next = 1'b0;
            end
        end
    end

    assign ram_re    = iss_reg;
    assign ram_raddr = addr_reg[AW-1:0];

    assign take = (s3_idx_reg == '0) || (s3_dist_reg < best_dist_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            iss_reg      <= 1'b0;
            addr_reg     <= '0;
            p0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end else begin
            iss_reg      <= iss_next;
            addr_reg     <= addr_next;
            p0_valid_reg <= iss_reg;
            s1_valid_reg <= p0_valid_reg;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            done_reg     <= s3_valid_reg && s3_last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            qx_reg <= qx;
            qy_reg <= qy;
            n_reg  <= count;
        end
        p0_last_reg <= iss_last;
        p0_idx_reg  <= addr_reg[AW-1:0];

        s1_last_reg <= p0_last_reg;
        s1_idx_reg  <= p0_idx_reg;
        s1_dx_reg   <= (rd_x >= qx_reg) ? (rd_x - qx_reg) : (qx_reg - rd_x);
        s1_dy_reg   <= (rd_y >= qy_reg) ? (rd_y - qy_reg) : (qy_reg - rd_y);
        s1_pal_reg  <= rd_pal;

        s2_last_reg <= s1_last_reg;
        s2_idx_reg  <= s1_idx_reg;
        s2_sqx_reg  <= SW'(s1_dx_reg) * SW'(s1_dx_reg);
        s2_sqy_reg  <= SW'(s1_dy_reg) * SW'(s1_dy_reg);
        s2_pal_reg  <= s1_pal_reg;

        s3_last_reg <= s2_last_reg;
        s3_idx_reg  <= s2_idx_reg;
        s3_dist_reg <= DW'(s2_sqx_reg) + DW'(s2_sqy_reg);
        s3_pal_reg  <= s2_pal_reg;

        if (s3_valid_reg && take) begin
            best_dist_reg <= s3_dist_reg;
            best_idx_reg  <= s3_idx_reg;
            best_pal_reg  <= s3_pal_reg;
        end
    end

    assign stat.busy = iss_reg || p0_valid_reg || s1_valid_reg || s2_valid_reg
                       || s3_valid_reg;
    assign stat.done = done_reg;
    assign best_site = best_idx_reg;
    assign best_pal  = best_pal_reg;

endmodule

[hw/rtl/voronoi_nearest_site_shader_top.sv]
// ----------------------------------------------------------------------------
// voronoi_nearest_site_shader_top
// Nearest-site Voronoi shader: site table load and pixel queries.
// ----------------------------------------------------------------------------
// Load: written to the site RAM at the accepting edge, no result; back to back.
// Query: the scan reads n sites from RAM (n = effective site count), then the
//   distance pipeline and compare, the divider, and the emit step raise m_tvalid.
// The next input is taken once the result is emitted, later while m_tready stalls.
// Reset (aresetn, sync, active low) clears control state and sets
//   site_count and colour_count to 1; site RAM contents are not cleared.
module voronoi_nearest_site_shader_top #(
    parameter int MAX_SITES  = vns_pkg::MAX_SITES_DEF,
    parameter int COORD_BITS = vns_pkg::COORD_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,

    // Input transactions
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [8:0] site_index, [23:9] coord_x, [38:24] coord_y, [44:39] palette_index
    input  logic [vns_pkg::S_TDATA_W-1:0]  s_tdata,
    // [0] operation (0 load, 1 query)
    input  logic                           s_tuser,

    // Result transactions
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [8:0] nearest_site, [16:9] shade
    output logic [vns_pkg::M_TDATA_W-1:0]  m_tdata,

    // Configuration writes
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [vns_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [vns_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int AW = $clog2(MAX_SITES);
    localparam int CW = $clog2(MAX_SITES + 1);
    localparam int PW = vns_pkg::PAL_W;
    localparam int RW = 2 * COORD_BITS + PW;
    localparam int IW = vns_pkg::SITE_IDX_W;
    localparam int XW = vns_pkg::COORD_W;
    localparam int HW = vns_pkg::SHADE_W;
    localparam int QW = vns_pkg::DIVIDEND_W;

    // ---------------- input field unpack ----------------
    logic [IW-1:0]         in_idx;
    logic [XW-1:0]         in_x, in_y;
    logic [PW-1:0]         in_pal;
    logic [COORD_BITS-1:0] in_x_c, in_y_c;
    logic                  in_accept;
    logic                  is_query;

    assign in_idx = s_tdata[IW-1:0];
    assign in_x   = s_tdata[IW+XW-1:IW];
    assign in_y   = s_tdata[IW+2*XW-1:IW+XW];
    assign in_pal = s_tdata[IW+2*XW+PW-1:IW+2*XW];
    // coordinates live in their low COORD_BITS bits
    assign in_x_c = COORD_BITS'(in_x);
    assign in_y_c = COORD_BITS'(in_y);

    assign in_accept = s_tvalid && s_tready;
    assign is_query  = (vns_pkg::op_t'(s_tuser) == vns_pkg::OP_QUERY);

    // ---------------- configuration ----------------
    logic [vns_pkg::SITE_COUNT_W-1:0]   site_count_reg;
    logic [vns_pkg::COLOUR_COUNT_W-1:0] colour_count_reg;
    logic [CW-1:0]                      n_eff;
    logic [vns_pkg::DIVISOR_W-1:0]      cc_eff;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            site_count_reg   <= vns_pkg::SITE_COUNT_W'(1);
            colour_count_reg <= vns_pkg::COLOUR_COUNT_W'(1);
        end else if (cfg_valid && cfg_ready) begin
            case (vns_pkg::cfg_idx_t'(cfg_index))
                vns_pkg::CFG_SITE_COUNT: begin
                    site_count_reg <= cfg_data[vns_pkg::SITE_COUNT_W-1:0];
                end
                vns_pkg::CFG_COLOUR_COUNT: begin
                    colour_count_reg <= cfg_data[vns_pkg::COLOUR_COUNT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // zero count scans site 0; count past the table saturates
    always_comb begin
        if (site_count_reg == '0) begin
            n_eff = CW'(1);
        end else if (32'(site_count_reg) > MAX_SITES) begin
            n_eff = CW'(MAX_SITES);
        end else begin
            n_eff = CW'(site_count_reg);
        end
        cc_eff = (colour_count_reg == '0) ? vns_pkg::DIVISOR_W'(1) : colour_count_reg;
    end

    // ---------------- sequencer ----------------
    vns_pkg::state_t state_reg, state_next;
    vns_pkg::scan_stat_t scan_stat;
    vns_pkg::div_req_t   div_req;
    logic                div_done;
    logic [QW-1:0]       quotient;

    logic          ram_we;
    logic          scan_start;
    logic          out_free;
    logic          emit_load;
    logic          load_ok;

    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [RW-1:0] ram_rdata;
    logic [AW-1:0] best_site;
    logic [PW-1:0] best_pal;

    // pending result between divider and output register
    logic [AW-1:0] res_site_reg;
    logic [HW-1:0] res_shade_reg;
    logic [HW-1:0] shade_c;

    // output register
    logic          m_tvalid_reg, m_tvalid_next;
    logic [IW-1:0] m_site_reg;
    logic [HW-1:0] m_shade_reg;

    assign out_free = !m_tvalid_reg || m_tready;
    // loads beyond the table are dropped
    assign load_ok  = (32'(in_idx) < MAX_SITES);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            vns_pkg::ST_IDLE: begin
                if (in_accept && is_query) begin
                    state_next = vns_pkg::ST_SCAN;
                end
            end
            vns_pkg::ST_SCAN: begin
                if (scan_stat.done) begin
                    state_next = vns_pkg::ST_DIV;
                end
            end
            vns_pkg::ST_DIV: begin
                if (div_done) begin
                    state_next = vns_pkg::ST_EMIT;
                end
            end
            vns_pkg::ST_EMIT: begin
                if (out_free) begin
                    state_next = vns_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = vns_pkg::ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        s_tready   = 1'b0;
        ram_we     = 1'b0;
        scan_start = 1'b0;
        emit_load  = 1'b0;
        case (state_reg)
            vns_pkg::ST_IDLE: begin
                s_tready   = 1'b1;
                ram_we     = in_accept && !is_query && load_ok;
                scan_start = in_accept && is_query;
            end
            vns_pkg::ST_EMIT: begin
                emit_load = out_free;
            end
            default: begin
            end
        endcase
    end

    // divider launched as the scan finishes; best_pal is valid with done
    assign div_req.start    = scan_stat.done && (state_reg == vns_pkg::ST_SCAN);
    assign div_req.dividend = QW'(best_pal) * vns_pkg::SHADE_SPAN;
    assign div_req.divisor  = cc_eff;

    // palette at or past colour_count caps at 225
    assign shade_c = (quotient > vns_pkg::SHADE_SPAN) ? vns_pkg::SHADE_MAX
                                                       : HW'(vns_pkg::SHADE_BASE + quotient);

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (emit_load) begin
            m_tvalid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= vns_pkg::ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        if (div_req.start) begin
            res_site_reg <= best_site;
        end
        if (div_done) begin
            res_shade_reg <= shade_c;
        end
        if (emit_load) begin
            m_site_reg  <= IW'(res_site_reg);
            m_shade_reg <= res_shade_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = vns_pkg::M_TDATA_W'({m_shade_reg, m_site_reg});

    // ---------------- datapath units ----------------
    // Site RAM entry: {palette, y, x}
    vns_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_SITES)
    ) u_site_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (AW'(in_idx)),
        .wdata ({in_pal, in_y_c, in_x_c}),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    vns_scan #(
        .MAX_SITES  (MAX_SITES),
        .COORD_BITS (COORD_BITS)
    ) u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (scan_start),
        .qx        (in_x_c),
        .qy        (in_y_c),
        .count     (n_eff),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .stat      (scan_stat),
        .best_site (best_site),
        .best_pal  (best_pal)
    );

    vns_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (div_req),
        .done     (div_done),
        .quotient (quotient)
    );

    // ---------------- assertions ----------------
    // no table write may land while a scan is reading
    a_no_write_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        scan_stat.busy |-> !ram_we)
        else $error("site RAM written during scan");

    // scanner only runs inside a query
    a_scan_in_state: assert property (@(posedge aclk) disable iff (!aresetn)
        scan_stat.busy |-> (state_reg == vns_pkg::ST_SCAN))
        else $error("scanner busy outside scan state");

    // divider finishes only while the sequencer waits for it
    a_div_in_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == vns_pkg::ST_DIV))
        else $error("divider done outside divide state");

    // a new result only comes from the emit step
    a_emit_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> ($past(state_reg) == vns_pkg::ST_EMIT))
        else $error("result raised outside emit");

    // shade stays in its range
    a_shade_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> ((m_shade_reg >= HW'(50)) && (m_shade_reg <= vns_pkg::SHADE_MAX)))
        else $error("shade out of range");

endmodule

[tb/sv/voronoi_nearest_site_shader_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// voronoi_nearest_site_shader_top_tb
// Self-checking bench for the nearest-site shader. Loads site entries and
// issues pixel queries over the stream ports with random idle and stall
// cycles on both sides. A local model of the site table predicts the
// nearest site and grey shade of each query. Results are compared in order.
// Register writes happen only between phases, once the block is idle.
// ----------------------------------------------------------------------------
module voronoi_nearest_site_shader_top_tb;
    import vns_pkg::*;

    localparam int SITES         = MAX_SITES_DEF;
    localparam int SETTLE_CYCLES = 40;    // loads are written at acceptance, results already back
    localparam int STALL_LIMIT   = 6000;  // ~10x a full 512-site scan plus stalls
    localparam int RANDOM_ITEMS  = 1170;
    localparam int MAX_REPORTS   = 20;

    typedef struct packed {
        op_t                   op;
        logic [SITE_IDX_W-1:0] idx;
        logic [COORD_W-1:0]    x;
        logic [COORD_W-1:0]    y;
        logic [PAL_W-1:0]      pal;
    } site_op_t;

    typedef struct packed {
        logic [SITE_IDX_W-1:0] site;
        logic [SHADE_W-1:0]    shade;
    } pixel_result_t;

    // Clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Block ports, inputs all known from time zero
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    voronoi_nearest_site_shader_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Site table model and register shadows
    logic [COORD_W-1:0]        site_x_mem   [SITES];
    logic [COORD_W-1:0]        site_y_mem   [SITES];
    logic [PAL_W-1:0]          site_pal_mem [SITES];
    logic [SITE_COUNT_W-1:0]   site_count_reg   = SITE_COUNT_W'(1);
    logic [COLOUR_COUNT_W-1:0] colour_count_reg = COLOUR_COUNT_W'(1);

    // Stimulus side bookkeeping: which entries have been queued for loading so far
    bit site_loaded [SITES];

    site_op_t      site_ops_pending [$];
    pixel_result_t shade_expected   [$];
    site_op_t      cur_item;

    bit steady = 1'b0;   // suppress idle/stall cycles on both sides
    int mismatches   = 0;
    int loads_done   = 0;
    int queries_done = 0;
    int results_seen = 0;
    int reg_writes   = 0;
    int items_queued = 0;
    int idle_cycles  = 0;

    // Zero is scanned as one site; anything past the table saturates
    function automatic int unsigned scan_len(logic [SITE_COUNT_W-1:0] count);
        if (count == 0) return 1;
        if (count > SITES) return SITES;
        return count;
    endfunction

    // Nearest site by squared distance, lower index wins on equal distance,
    // then the shade 50 + floor(pal * 175 / colour_count) capped at 225.
    function automatic pixel_result_t nearest_site_shade(logic [COORD_W-1:0] px,
                                                         logic [COORD_W-1:0] py);
        int unsigned       n;
        int unsigned       cc;
        int unsigned       best;
        int unsigned       shade;
        longint unsigned   dx;
        longint unsigned   dy;
        longint unsigned   sq_dist;
        longint unsigned   best_dist;
        pixel_result_t     res;
        n         = scan_len(site_count_reg);
        cc        = (colour_count_reg == 0) ? 1 : colour_count_reg;
        best      = 0;
        best_dist = 0;
        for (int unsigned i = 0; i < n; i++) begin
            dx      = (site_x_mem[i] > px) ? site_x_mem[i] - px : px - site_x_mem[i];
            dy      = (site_y_mem[i] > py) ? site_y_mem[i] - py : py - site_y_mem[i];
            sq_dist = dx * dx + dy * dy;
            if (i == 0 || sq_dist < best_dist) begin
                best      = i;
                best_dist = sq_dist;
            end
        end
        shade = 50 + (site_pal_mem[best] * 175) / cc;
        if (shade > 225) shade = 225;
        res.site  = SITE_IDX_W'(best);
        res.shade = SHADE_W'(shade);
        return res;
    endfunction

    function automatic bit gap_now();
        return !steady && ($urandom_range(99) < 23);
    endfunction

    // ------------------------------------------------------------------
    // Driver: pops pending items; the model is updated at the accepting
    // edge, so expectations line up with transaction order.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                if (cur_item.op == OP_LOAD) begin
                    site_x_mem[cur_item.idx]   = cur_item.x;
                    site_y_mem[cur_item.idx]   = cur_item.y;
                    site_pal_mem[cur_item.idx] = cur_item.pal;
                    loads_done++;
                end else begin
                    shade_expected.push_back(nearest_site_shade(cur_item.x, cur_item.y));
                    queries_done++;
                end
            end
            if (!s_tvalid || s_tready) begin
                if (site_ops_pending.size() != 0 && !gap_now()) begin
                    cur_item = site_ops_pending.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {3'b000, cur_item.pal, cur_item.y, cur_item.x, cur_item.idx};
                    s_tuser  <= cur_item.op;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: every result transaction is matched against the oldest
    // expectation, field by field.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        pixel_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (shade_expected.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: unexpected result, expected none, got site %0d shade %0d",
                                 $time, m_tdata[8:0], m_tdata[16:9]);
                end else begin
                    want = shade_expected.pop_front();
                    if (m_tdata[8:0] !== want.site) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("%0t: nearest_site expected %0d, got %0d",
                                     $time, want.site, m_tdata[8:0]);
                    end
                    if (m_tdata[16:9] !== want.shade) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("%0t: shade expected %0d, got %0d",
                                     $time, want.shade, m_tdata[16:9]);
                    end
                end
            end
            m_tready <= !gap_now();
        end
    end

    // Watchdog: ends the run when no transaction of any kind moves
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                     $time, STALL_LIMIT, shade_expected.size());
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_load(int unsigned idx, logic [COORD_W-1:0] x,
                              logic [COORD_W-1:0] y, logic [PAL_W-1:0] pal);
        site_op_t item;
        item.op  = OP_LOAD;
        item.idx = SITE_IDX_W'(idx);
        item.x   = x;
        item.y   = y;
        item.pal = pal;
        site_ops_pending.push_back(item);
        site_loaded[idx] = 1'b1;
        items_queued++;
    endtask

    // Query: site_index and palette carry random junk, the block ignores them
    task automatic queue_query(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
        site_op_t item;
        item.op  = OP_QUERY;
        item.idx = SITE_IDX_W'($urandom);
        item.x   = x;
        item.y   = y;
        item.pal = PAL_W'($urandom);
        site_ops_pending.push_back(item);
        items_queued++;
    endtask

    // Mix of edge values, a tiny cluster (frequent distance ties) and full range
    function automatic logic [COORD_W-1:0] pick_coord();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 15) return $urandom_range(1) ? {COORD_W{1'b1}} : '0;
        if (r < 35) return COORD_W'($urandom_range(7));
        return COORD_W'($urandom);
    endfunction

    // Drain everything, then let the block go quiet before touching registers
    task automatic settle();
        do @(negedge aclk);
        while (site_ops_pending.size() != 0 || s_tvalid || shade_expected.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_SITE_COUNT) site_count_reg = value;
        else colour_count_reg = value[COLOUR_COUNT_W-1:0];
        reg_writes++;
    endtask

    // One phase: new register values, make sure every scanned entry holds a
    // site, then a random mix of loads and queries.
    task automatic run_phase(logic [CFG_DATA_W-1:0] sc, logic [CFG_DATA_W-1:0] cc,
                             int count, bit no_gaps);
        int unsigned n;
        settle();
        write_reg(CFG_SITE_COUNT, sc);
        write_reg(CFG_COLOUR_COUNT, cc);
        @(negedge aclk);
        steady <= no_gaps;
        n = scan_len(sc);
        for (int unsigned i = 0; i < n; i++)
            if (!site_loaded[i]) queue_load(i, pick_coord(), pick_coord(), PAL_W'($urandom));
        repeat (count) begin
            if ($urandom_range(99) < 45)
                queue_load(($urandom_range(99) < 60) ? $urandom_range(n - 1) : $urandom_range(SITES - 1),
                           pick_coord(), pick_coord(), PAL_W'($urandom));
            else
                queue_query(pick_coord(), pick_coord());
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int                       phase;
        bit                       table_full;
        logic [CFG_DATA_W-1:0]    sc;
        logic [CFG_DATA_W-1:0]    cc;
        int unsigned              pick;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset defaults: one site, one colour, so a full palette saturates
        queue_load(0, '0, '0, 6'd63);
        queue_query(15'h7FFF, 15'h7FFF);

        // Corners, a duplicate site for ties, and two sites equally near one pixel
        settle();
        write_reg(CFG_SITE_COUNT, 10'd8);
        write_reg(CFG_COLOUR_COUNT, 10'd64);
        @(negedge aclk);
        queue_load(1, 15'h7FFF, 15'h7FFF, 6'd0);
        queue_load(2, 15'h7FFF, 15'h0000, 6'd42);
        queue_load(3, 15'h0000, 15'h7FFF, 6'd21);
        queue_load(4, 15'h7FFF, 15'h7FFF, 6'd7);
        queue_load(5, 15'd16384, 15'd16384, 6'd63);
        queue_load(6, 15'd5, 15'd5, 6'd1);
        queue_load(7, 15'd4, 15'd6, 6'd62);
        queue_load(511, 15'h5555, 15'h2AAA, 6'h2A);
        queue_query(15'h0000, 15'h0000);
        queue_query(15'h7FFF, 15'h7FFF);
        queue_query(15'h7FFF, 15'h0000);
        queue_query(15'h0000, 15'h7FFF);
        queue_query(15'd16384, 15'd16384);
        queue_query(15'd5, 15'd6);
        queue_query(15'd16383, 15'd16385);

        // Zero site count scans site 0; zero colour count acts as one
        settle();
        write_reg(CFG_SITE_COUNT, 10'd0);
        write_reg(CFG_COLOUR_COUNT, 10'd0);
        @(negedge aclk);
        queue_query(15'd100, 15'd100);

        // Largest colour count the register holds
        settle();
        write_reg(CFG_COLOUR_COUNT, 10'd127);
        @(negedge aclk);
        queue_query(15'd0, 15'd0);

        // Random phases. Early ones keep the scan short; phase 3 fills the
        // whole table at full size, after which any count may be used.
        items_queued = 0;
        table_full   = 1'b0;
        phase        = 0;
        while (items_queued < RANDOM_ITEMS) begin
            pick = $urandom_range(99);
            if (pick < 15) begin
                case ($urandom_range(3))
                    0: cc = 10'd0;
                    1: cc = 10'd1;
                    2: cc = 10'd64;
                    default: cc = 10'd127;
                endcase
            end else begin
                cc = CFG_DATA_W'($urandom_range(1, 127));
            end
            if (phase == 3) begin
                sc = 10'd512;
                table_full = 1'b1;
                run_phase(sc, cc, 20, 1'b0);
            end else if (phase == 4) begin
                run_phase(10'd1023, cc, 20, 1'b0);
            end else if (table_full && $urandom_range(99) < 10) begin
                sc = ($urandom_range(1)) ? 10'd512 : CFG_DATA_W'($urandom_range(513, 1023));
                run_phase(sc, cc, $urandom_range(8, 16), 1'b0);
            end else begin
                sc = ($urandom_range(99) < 8) ? 10'd0 : CFG_DATA_W'($urandom_range(1, 40));
                run_phase(sc, cc, $urandom_range(20, 60), phase == 6);
            end
            phase++;
        end

        settle();
        $display("Covered %0d loads, %0d queries, %0d results checked, %0d register writes,",
                 loads_done, queries_done, results_seen, reg_writes);
        $display("over %0d random phases with saturated, zero and full-table scan counts.", phase);
        if (mismatches == 0 && shade_expected.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

[files.f]
hw/rtl/vns_pkg.sv
hw/rtl/vns_ram.sv
hw/rtl/vns_div.sv
hw/rtl/vns_scan.sv
hw/rtl/voronoi_nearest_site_shader_top.sv
tb/sv/voronoi_nearest_site_shader_top_tb.sv
